// File: design/srrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrp_pkg
// Sizes, types and constants of the signature-based RRIP replacement core.
// ----------------------------------------------------------------------------
package srrp_pkg;

    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int CTR_ENTRIES = 8192;
    localparam int RRPV_WIDTH  = 2;

    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int SIG_W     = $clog2(CTR_ENTRIES);
    localparam int SIG_SHIFT = 4;
    localparam int CTR_W     = 2;

    localparam int ROW_W  = WAYS * RRPV_WIDTH;
    localparam int SROW_W = WAYS * SIG_W;

    localparam int CLR_DEPTH = (SETS > CTR_ENTRIES) ? SETS : CTR_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    typedef logic [RRPV_WIDTH-1:0] t_rrpv;
    typedef logic [CTR_W-1:0]      t_ctr;
    typedef logic [SIG_W-1:0]      t_sig;

    localparam t_rrpv RRPV_MAX = {RRPV_WIDTH{1'b1}};
    localparam t_ctr  CTR_MAX  = 2'd3;
    localparam t_ctr  CTR_INIT = 2'd1;
    localparam logic [1:0] THRESH_RESET = 2'd2;

    localparam logic ACT_QUERY  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_UPD,
        ST_FILL
    } t_state;

endpackage : srrp_pkg
`default_nettype wire

// File: design/ship_rrip_replacement_policy_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ship_rrip_replacement_policy_core
// Signature-based RRIP replacement policy: victim selection with set aging,
// hit promotion and fill insertion steered by per-signature reuse counters.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass over CLR_DEPTH (8192)
// addresses, one address of every memory a cycle, with o_in_stall high;
// configuration writes are taken throughout. Items are then handled one
// at a time: a victim query or a hit reads the set rows and the counter
// table and then writes back; a miss fill needs a second counter read
// for the evicted line's signature before its write-back. An update
// whose way is out of range is dropped. The victim sits in an output
// register, so a waiting result stalls a following query only at its
// write-back.
module ship_rrip_replacement_policy_core
    import srrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [10:0] i_set_index,
    input  wire logic [3:0]  i_way_index,
    input  wire logic [47:0] i_pc,
    input  wire logic        i_hit_flag,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [3:0]       o_victim_way,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_reuse_threshold
);

    // memories
    logic [ROW_W-1:0]  r_rrpv_mem [SETS];
    logic [SROW_W-1:0] r_sig_mem  [SETS];
    t_ctr              r_ctr_mem  [CTR_ENTRIES];

    logic [ROW_W-1:0]  r_rrpv_q;
    logic [SROW_W-1:0] r_sig_q;
    t_ctr              r_ctr_q;

    // control and item registers
    t_state            r_state, n_state;
    logic [CLR_W-1:0]  r_clr, n_clr;
    logic [1:0]        r_thresh;
    logic              r_out_valid, n_out_valid;
    logic [3:0]        r_victim, n_victim;
    logic [SET_W-1:0]  r_set, n_set;
    logic [WAY_W-1:0]  r_way, n_way;
    t_sig              r_sig, n_sig;
    logic              r_hit_q, n_hit;
    t_sig              r_old_sig, n_old_sig;
    t_ctr              r_ctr_new, n_ctr_new;

    // memory port controls
    logic              rrpv_we, sig_we, ctr_we;
    logic [SET_W-1:0]  rrpv_wa;
    logic [ROW_W-1:0]  rrpv_wd;
    logic [SROW_W-1:0] sig_wd;
    t_sig              ctr_wa;
    t_ctr              ctr_wd;
    logic              row_re, ctr_re;
    t_sig              ctr_ra;

    logic              accept, out_free, way_ok, clr_last;
    t_sig              in_sig, row_old_sig;
    logic [ROW_W-1:0]  aged_row;
    logic [3:0]        victim;
    t_rrpv             top, lift;
    logic [(1<<RRPV_WIDTH)-1:0] present;
    t_ctr              ctr_inc, ctr_dec, ctr_eff;

    assign accept      = (r_state == ST_IDLE) && i_in_valid;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign way_ok      = 32'(i_way_index) < WAYS;
    assign clr_last    = r_clr == CLR_W'(CLR_DEPTH - 1);
    assign in_sig      = i_pc[SIG_SHIFT +: SIG_W];
    assign row_old_sig = r_sig_q[r_way*SIG_W +: SIG_W];
    assign ctr_inc     = (r_ctr_q == CTR_MAX) ? r_ctr_q : r_ctr_q + t_ctr'(1);
    assign ctr_dec     = (r_ctr_q == '0) ? r_ctr_q : r_ctr_q - t_ctr'(1);
    // count-down lands first when both lines share a signature
    assign ctr_eff     = (r_old_sig == r_sig) ? ctr_dec : r_ctr_new;

    // aging: lift every way by the gap between the set's top value and max
    always_comb begin
        present = '0;
        for (int w = 0; w < WAYS; w++) begin
            present[r_rrpv_q[w*RRPV_WIDTH +: RRPV_WIDTH]] = 1'b1;
        end
        top = '0;
        for (int v = 0; v < (1 << RRPV_WIDTH); v++) begin
            if (present[v]) top = t_rrpv'(v);
        end
        lift = RRPV_MAX - top;
        for (int w = 0; w < WAYS; w++) begin
            aged_row[w*RRPV_WIDTH +: RRPV_WIDTH] =
                r_rrpv_q[w*RRPV_WIDTH +: RRPV_WIDTH] + lift;
        end
        // first way that held the top value
        victim = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rrpv_q[w*RRPV_WIDTH +: RRPV_WIDTH] == top) victim = 4'(w);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_QUERY)  n_state = ST_QUERY;
                    else if (way_ok)            n_state = ST_UPD;
                end
            end
            ST_QUERY: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_UPD: begin
                n_state = r_hit_q ? ST_IDLE : ST_FILL;
            end
            ST_FILL:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        n_victim    = r_victim;
        n_set       = r_set;
        n_way       = r_way;
        n_sig       = r_sig;
        n_hit       = r_hit_q;
        n_old_sig   = r_old_sig;
        n_ctr_new   = r_ctr_new;
        rrpv_we     = 1'b0;
        sig_we      = 1'b0;
        ctr_we      = 1'b0;
        rrpv_wa     = r_set;
        rrpv_wd     = r_rrpv_q;
        sig_wd      = r_sig_q;
        ctr_wa      = r_sig;
        ctr_wd      = r_ctr_q;
        row_re      = 1'b0;
        ctr_re      = 1'b0;
        ctr_ra      = in_sig;
        case (r_state)
            ST_CLEAR: begin
                n_clr   = r_clr + CLR_W'(1);
                rrpv_we = 32'(r_clr) < SETS;
                sig_we  = 32'(r_clr) < SETS;
                ctr_we  = 32'(r_clr) < CTR_ENTRIES;
                rrpv_wa = r_clr[SET_W-1:0];
                rrpv_wd = {WAYS{RRPV_MAX}};
                sig_wd  = '0;
                ctr_wa  = r_clr[SIG_W-1:0];
                ctr_wd  = CTR_INIT;
            end
            ST_IDLE: begin
                if (accept) begin
                    row_re = 1'b1;
                    ctr_re = 1'b1;
                    ctr_ra = in_sig;
                    n_set  = i_set_index[SET_W-1:0];
                    n_way  = i_way_index[WAY_W-1:0];
                    n_sig  = in_sig;
                    n_hit  = i_hit_flag;
                end
            end
            ST_QUERY: begin
                if (out_free) begin
                    rrpv_we     = 1'b1;
                    rrpv_wd     = aged_row;
                    n_out_valid = 1'b1;
                    n_victim    = victim;
                end
            end
            ST_UPD: begin
                if (r_hit_q) begin
                    rrpv_we = 1'b1;
                    rrpv_wd[r_way*RRPV_WIDTH +: RRPV_WIDTH] = '0;
                    ctr_we  = 1'b1;
                    ctr_wa  = r_sig;
                    ctr_wd  = ctr_inc;
                end else begin
                    ctr_re    = 1'b1;
                    ctr_ra    = row_old_sig;
                    n_old_sig = row_old_sig;
                    n_ctr_new = r_ctr_q;
                end
            end
            ST_FILL: begin
                ctr_we  = 1'b1;
                ctr_wa  = r_old_sig;
                ctr_wd  = ctr_dec;
                rrpv_we = 1'b1;
                rrpv_wd[r_way*RRPV_WIDTH +: RRPV_WIDTH] =
                    (ctr_eff >= r_thresh) ? t_rrpv'(0) : RRPV_MAX;
                sig_we  = 1'b1;
                sig_wd[r_way*SIG_W +: SIG_W] = r_sig;
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall   = r_state != ST_IDLE;
        o_out_valid  = r_out_valid;
        o_victim_way = r_victim;
        o_cfg_ready  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_thresh    <= THRESH_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) r_thresh <= i_cfg_reuse_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        r_victim  <= n_victim;
        r_set     <= n_set;
        r_way     <= n_way;
        r_sig     <= n_sig;
        r_hit_q   <= n_hit;
        r_old_sig <= n_old_sig;
        r_ctr_new <= n_ctr_new;
    end

    always_ff @(posedge i_clk) begin
        if (rrpv_we) r_rrpv_mem[rrpv_wa] <= rrpv_wd;
        if (row_re)  r_rrpv_q <= r_rrpv_mem[n_set];
    end

    always_ff @(posedge i_clk) begin
        if (sig_we) r_sig_mem[rrpv_wa] <= sig_wd;
        if (row_re) r_sig_q <= r_sig_mem[n_set];
    end

    always_ff @(posedge i_clk) begin
        if (ctr_we) r_ctr_mem[ctr_wa] <= ctr_wd;
        if (ctr_re) r_ctr_q <= r_ctr_mem[ctr_ra];
    end

endmodule : ship_rrip_replacement_policy_core
`default_nettype wire
